// File: rtl/core/lse_pkg.sv
// Shared types and constants for the LSB stego extractor.
`default_nettype none

package lse_pkg;

    // Longest magic string the checker supports
    localparam int unsigned MAGIC_MAX_CHARS = 8;

    // Configuration register indexes
    localparam logic [1:0] CFG_HEADER_BYTES = 2'd0;
    localparam logic [1:0] CFG_MAGIC_LENGTH = 2'd1;
    localparam logic [1:0] CFG_MAGIC_CHARS  = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_EXT   = 2'd0;
    localparam logic [1:0] KIND_PAY   = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // Error codes
    localparam logic [2:0] ERR_NONE         = 3'd0;
    localparam logic [2:0] ERR_ZERO_MAGIC   = 3'd1;
    localparam logic [2:0] ERR_MAGIC_DIFF   = 3'd2;
    localparam logic [2:0] ERR_ZERO_EXT     = 3'd3;
    localparam logic [2:0] ERR_NO_DOT       = 3'd4;
    localparam logic [2:0] ERR_ZERO_PAYLOAD = 3'd5;

    // ASCII '.'
    localparam logic [7:0] CHAR_DOT = 8'h2E;

    // One result item
    typedef struct packed {
        logic [7:0] data;
        logic [1:0] kind;
        logic [2:0] err;
        logic       last;
    } lse_result_t;

endpackage

`default_nettype wire

// File: rtl/core/lse_decoder.sv
// Frame decoder: header skip, bit gathering, magic check and result forming.
`default_nettype none

module lse_decoder (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               take,
    input  wire logic [7:0]         image_byte,
    input  wire logic               frame_start,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [63:0]        cfg_data,
    output logic                    res_valid,
    output lse_pkg::lse_result_t    res
);
    import lse_pkg::*;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_MAGIC_LEN,
        PH_MAGIC_CHARS,
        PH_EXT_LEN,
        PH_EXT_CHARS,
        PH_PAY_LEN,
        PH_PAY_DATA,
        PH_IDLE
    } phase_t;

    // Configuration
    logic [15:0] header_bytes_reg;
    logic [3:0]  magic_length_reg;
    logic [63:0] magic_chars_reg;

    // Decoder state
    phase_t      phase_reg,    phase_next;
    logic [4:0]  bit_idx_reg,  bit_idx_next;
    logic [31:0] shift_reg,    shift_next;
    logic [31:0] rem_reg,      rem_next;
    logic [2:0]  char_idx_reg, char_idx_next;
    logic        mismatch_reg, mismatch_next;
    logic        ext_first_reg, ext_first_next;

    logic        magic_len_ok;
    logic [31:0] shifted;
    logic [7:0]  want_char;
    logic [31:0] rem_dec;

    assign magic_len_ok = (magic_length_reg != 4'd0) &&
                          (magic_length_reg <= 4'(MAGIC_MAX_CHARS));

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_bytes_reg <= 16'd54;
            magic_length_reg <= 4'd1;
            magic_chars_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_HEADER_BYTES: header_bytes_reg <= cfg_data[15:0];
                CFG_MAGIC_LENGTH: magic_length_reg <= cfg_data[3:0];
                CFG_MAGIC_CHARS:  magic_chars_reg  <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Next state and result for the item on the input
    always_comb
    begin
        phase_next     = phase_reg;
        bit_idx_next   = bit_idx_reg;
        shift_next     = shift_reg;
        rem_next       = rem_reg;
        char_idx_next  = char_idx_reg;
        mismatch_next  = mismatch_reg;
        ext_first_next = ext_first_reg;
        res_valid      = 1'b0;
        res            = '{data: 8'd0, kind: KIND_ERROR, err: ERR_NONE, last: 1'b1};

        // frame start restarts decoding on this item
        if (frame_start)
        begin
            phase_next     = PH_HEADER;
            bit_idx_next   = '0;
            shift_next     = '0;
            rem_next       = '0;
            char_idx_next  = '0;
            mismatch_next  = 1'b0;
            ext_first_next = 1'b1;
        end

        shifted   = shift_next | (32'(image_byte[0]) << bit_idx_next);
        want_char = magic_chars_reg[{char_idx_next, 3'b000} +: 8];
        rem_dec   = rem_next - 32'd1;

        if (phase_next == PH_HEADER && rem_next < {16'd0, header_bytes_reg})
        begin
            rem_next = rem_next + 32'd1;
        end
        else
        begin
            if (phase_next == PH_HEADER)
            begin
                rem_next   = '0;
                phase_next = PH_MAGIC_LEN;
            end

            unique case (phase_next)
                PH_MAGIC_LEN, PH_EXT_LEN, PH_PAY_LEN:
                begin
                    if (bit_idx_next == 5'd31)
                    begin
                        bit_idx_next = '0;
                        shift_next   = '0;
                        if (shifted == 32'd0)
                        begin
                            res_valid  = 1'b1;
                            if (phase_next == PH_MAGIC_LEN)
                                res.err = ERR_ZERO_MAGIC;
                            else if (phase_next == PH_EXT_LEN)
                                res.err = ERR_ZERO_EXT;
                            else
                                res.err = ERR_ZERO_PAYLOAD;
                            phase_next = PH_IDLE;
                        end
                        else if (phase_next == PH_MAGIC_LEN)
                        begin
                            if (!magic_len_ok || shifted != {28'd0, magic_length_reg})
                            begin
                                res_valid  = 1'b1;
                                res.err    = ERR_MAGIC_DIFF;
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                rem_next      = shifted;
                                char_idx_next = '0;
                                mismatch_next = 1'b0;
                                phase_next    = PH_MAGIC_CHARS;
                            end
                        end
                        else if (phase_next == PH_EXT_LEN)
                        begin
                            rem_next       = shifted;
                            ext_first_next = 1'b1;
                            phase_next     = PH_EXT_CHARS;
                        end
                        else
                        begin
                            rem_next   = shifted;
                            phase_next = PH_PAY_DATA;
                        end
                    end
                    else
                    begin
                        shift_next   = shifted;
                        bit_idx_next = bit_idx_next + 5'd1;
                    end
                end

                PH_MAGIC_CHARS, PH_EXT_CHARS, PH_PAY_DATA:
                begin
                    if (bit_idx_next == 5'd7)
                    begin
                        bit_idx_next = '0;
                        shift_next   = '0;
                        rem_next     = rem_dec;
                        if (phase_next == PH_MAGIC_CHARS)
                        begin
                            mismatch_next = mismatch_next || (want_char != shifted[7:0]);
                            char_idx_next = char_idx_next + 3'd1;
                            if (rem_dec == 32'd0)
                            begin
                                if (mismatch_next)
                                begin
                                    res_valid  = 1'b1;
                                    res.err    = ERR_MAGIC_DIFF;
                                    phase_next = PH_IDLE;
                                end
                                else
                                    phase_next = PH_EXT_LEN;
                            end
                        end
                        else if (phase_next == PH_EXT_CHARS)
                        begin
                            res_valid = 1'b1;
                            if (ext_first_next && shifted[7:0] != CHAR_DOT)
                            begin
                                res.err    = ERR_NO_DOT;
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                res            = '{data: shifted[7:0], kind: KIND_EXT,
                                                   err: ERR_NONE, last: 1'b0};
                                ext_first_next = 1'b0;
                                if (rem_dec == 32'd0)
                                    phase_next = PH_PAY_LEN;
                            end
                        end
                        else
                        begin
                            res_valid = 1'b1;
                            res       = '{data: shifted[7:0], kind: KIND_PAY,
                                          err: ERR_NONE, last: (rem_dec == 32'd0)};
                            if (rem_dec == 32'd0)
                                phase_next = PH_IDLE;
                        end
                    end
                    else
                    begin
                        shift_next   = shifted;
                        bit_idx_next = bit_idx_next + 5'd1;
                    end
                end

                PH_HEADER, PH_IDLE:
                begin
                    // nothing collected after the end or an error
                end
            endcase
        end
    end

    // State registers, updated on each accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            bit_idx_reg   <= '0;
            shift_reg     <= '0;
            rem_reg       <= '0;
            char_idx_reg  <= '0;
            mismatch_reg  <= 1'b0;
            ext_first_reg <= 1'b1;
        end
        else if (take)
        begin
            phase_reg     <= phase_next;
            bit_idx_reg   <= bit_idx_next;
            shift_reg     <= shift_next;
            rem_reg       <= rem_next;
            char_idx_reg  <= char_idx_next;
            mismatch_reg  <= mismatch_next;
            ext_first_reg <= ext_first_next;
        end
    end

    // Byte groups never reach past bit 7
    a_byte_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_MAGIC_CHARS || phase_reg == PH_EXT_CHARS ||
         phase_reg == PH_PAY_DATA) |-> bit_idx_reg <= 5'd7)
        else $error("bit index beyond byte group");

    // An error result always ends the frame
    a_err_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (take && res_valid && res.kind == KIND_ERROR) |=> phase_reg == PH_IDLE)
        else $error("error result without end of frame");

    // Error results carry a code and the last mark, data results carry no code
    a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> ((res.kind == KIND_ERROR) == (res.err != ERR_NONE)) &&
                      (res.kind != KIND_ERROR || res.last))
        else $error("result code inconsistent with kind");

endmodule

`default_nettype wire

// File: rtl/core/lse_out_queue.sv
// Two-entry result queue that parts the decoder from the output handshake.
`default_nettype none

module lse_out_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire lse_pkg::lse_result_t push_data,
    output logic                    has_room,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output lse_pkg::lse_result_t    head
);
    import lse_pkg::*;

    lse_result_t slot0_reg, slot0_next;
    lse_result_t slot1_reg, slot1_next;
    logic [1:0]  count_reg, count_next;
    logic        pop;

    assign has_room  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign head      = slot0_reg;
    assign pop       = out_valid && out_ready;

    // Slot moves for push and pop
    always_comb
    begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        count_next = count_reg;
        if (push && !pop)
        begin
            if (count_reg == 2'd0)
                slot0_next = push_data;
            else
                slot1_next = push_data;
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            slot0_next = slot1_reg;
            count_next = count_reg - 2'd1;
        end
        else if (pop && push)
        begin
            if (count_reg == 2'd1)
                slot0_next = push_data;
            else
            begin
                slot0_next = slot1_reg;
                slot1_next = push_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> has_room)
        else $error("push into full queue");

    a_pushed_shows: assert property (@(posedge clk) disable iff (!rst_n)
        (push && count_reg == 2'd0) |=> (out_valid && head == $past(push_data)))
        else $error("pushed item not at head");

endmodule

`default_nettype wire

// File: rtl/core/lsb_stego_extractor.sv
// Top level of the LSB steganography extractor.
`default_nettype none

// Takes one carrier image byte per cycle while in_ready is high, skips
// header_bytes bytes, then gathers bit 0 of each byte LSB first into the
// hidden frame: magic length, magic characters, extension length, extension
// characters, payload length and payload bytes. Extension characters and
// payload bytes come out as items; a failed check gives one error item and
// the frame then ignores input until frame_start. An input item is taken
// when in_valid and in_ready are both high; its result, if any, enters the
// output queue at acceptance; with the queue empty it is visible at the
// output in the cycle after acceptance, otherwise it waits behind the older
// results. A two-entry result queue sits at the output; in_ready drops only
// while both entries hold results that the sink has not taken. Configuration
// writes are single cycle writes through cfg_we, cfg_index and cfg_data.
module lsb_stego_extractor (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  image_byte,
    input  wire logic        frame_start,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       out_byte,
    output logic [1:0]       out_kind,
    output logic [2:0]       error_code,
    output logic             last_byte,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);
    import lse_pkg::*;

    logic        take;
    logic        res_valid;
    lse_result_t res;
    lse_result_t head;

    assign take = in_valid && in_ready;

    // Decoder state and result logic
    lse_decoder u_decoder (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .image_byte  (image_byte),
        .frame_start (frame_start),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .res_valid   (res_valid),
        .res         (res)
    );

    // Result queue
    lse_out_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (take && res_valid),
        .push_data (res),
        .has_room  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    assign out_byte   = head.data;
    assign out_kind   = head.kind;
    assign error_code = head.err;
    assign last_byte  = head.last;

endmodule

`default_nettype wire
